/* hw/rtl/rc4_pkg.sv */
// Shared types and constants for the RC4 stream cipher block.
package rc4_pkg;

  localparam int unsigned ByteW = 8;
  localparam int unsigned KeyW  = 64;

  localparam logic CMD_CRYPT = 1'b0;
  localparam logic CMD_REKEY = 1'b1;

  typedef enum logic [7:0] {
    ST_IDLE = 8'b0000_0001,
    ST_RDJ  = 8'b0000_0010,
    ST_SWP  = 8'b0000_0100,
    ST_FILL = 8'b0000_1000,
    ST_KRN  = 8'b0001_0000,
    ST_KRA  = 8'b0010_0000,
    ST_KWN  = 8'b0100_0000,
    ST_KWA  = 8'b1000_0000
  } state_t;

endpackage

/* hw/rtl/rc4_stream_cipher.sv */
// RC4 stream cipher top level: permutation table memory, key schedule and keystream.
// Crypt: after states RDJ and SWP the result is registered on out_tdata (hold slot on a stall).
// A new crypt is taken only in idle, after the three dependent reads of the table memory.
// Rekey: fills the table, then runs KRN, KRA, KWN and KWA for each table entry; no result.
// Reset (rst_n, synchronous): clears key, indices and control; the table is
// undefined until the first rekey.
module rc4_stream_cipher (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] data_byte
  input  logic [0:0]  in_tuser,   // [0] command
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // [7:0] result_byte
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [63:0] cfg_data
);

  rc4_pkg::state_t state_r, state_nxt;

  logic [7:0] mem [256];
  logic [7:0] rd_data_r;
  logic [7:0] rd_addr;
  logic       mem_we;
  logic [7:0] mem_waddr, mem_wdata;

  logic [63:0] key_r, key_nxt;
  logic [7:0]  i_r, i_nxt, j_r, j_nxt;
  logic        pend_r, pend_nxt;
  logic [7:0]  pj_r, pj_nxt, pdata_r, pdata_nxt;
  logic        fwd_r, fwd_nxt;
  logic [7:0]  si_r, si_nxt, sj_r, sj_nxt;
  logic        kfi_r, kfi_nxt, kfj_r, kfj_nxt;
  logic [7:0]  data_r, data_nxt;
  logic        ksv_r, ksv_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic [7:0]  out_data_r, out_data_nxt;
  logic        hold_v_r, hold_v_nxt;
  logic [7:0]  hold_data_r, hold_data_nxt;
  logic [7:0]  n_r, n_nxt, acc_r, acc_nxt, sn_r, sn_nxt;

  logic [7:0] i_inc, si, sj, t_addr, ks, res, kb, acc_sum;
  logic       out_free, in_acc;

  assign cfg_ready  = 1'b1;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  assign i_inc    = i_r + 8'd1;
  assign out_free = !out_valid_r || out_tready;
  assign in_tready = (state_r == rc4_pkg::ST_IDLE) && !hold_v_r && !(ksv_r && !out_free);
  assign in_acc   = in_tvalid && in_tready;

  // keystream byte, forwarding the swap writes not yet visible in the read data
  assign ks  = kfj_r ? si_r : (kfi_r ? sj_r : rd_data_r);
  assign res = ks ^ data_r;
  assign si  = fwd_r ? pdata_r : rd_data_r;
  assign sj  = rd_data_r;
  assign t_addr  = si_r + sj;
  assign kb      = key_r[{n_r[2:0], 3'b000} +: 8];
  assign acc_sum = acc_r + rd_data_r + kb;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_data_r <= mem[rd_addr];
  end

  always_comb begin
    state_nxt     = state_r;
    key_nxt       = key_r;
    i_nxt         = i_r;
    j_nxt         = j_r;
    pend_nxt      = pend_r;
    pj_nxt        = pj_r;
    pdata_nxt     = pdata_r;
    fwd_nxt       = fwd_r;
    si_nxt        = si_r;
    sj_nxt        = sj_r;
    kfi_nxt       = kfi_r;
    kfj_nxt       = kfj_r;
    data_nxt      = data_r;
    ksv_nxt       = 1'b0;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    hold_v_nxt    = hold_v_r;
    hold_data_nxt = hold_data_r;
    n_nxt         = n_r;
    acc_nxt       = acc_r;
    sn_nxt        = sn_r;
    mem_we        = 1'b0;
    mem_waddr     = pj_r;
    mem_wdata     = pdata_r;
    rd_addr       = i_inc;

    if (cfg_valid) begin
      key_nxt = cfg_data;
    end

    // result path: output register with one hold slot behind it
    if (out_free) begin
      if (hold_v_r) begin
        out_valid_nxt = 1'b1;
        out_data_nxt  = hold_data_r;
        hold_v_nxt    = 1'b0;
      end else if (ksv_r) begin
        out_valid_nxt = 1'b1;
        out_data_nxt  = res;
      end else begin
        out_valid_nxt = 1'b0;
      end
    end else if (ksv_r) begin
      hold_v_nxt    = 1'b1;
      hold_data_nxt = res;
    end

    unique case (state_r)
      rc4_pkg::ST_IDLE: begin
        if (pend_r) begin
          mem_we   = 1'b1;
          pend_nxt = 1'b0;
        end
        if (in_acc) begin
          if (in_tuser[0] == rc4_pkg::CMD_REKEY) begin
            n_nxt     = 8'd0;
            state_nxt = rc4_pkg::ST_FILL;
          end else begin
            i_nxt     = i_inc;
            fwd_nxt   = pend_r && (pj_r == i_inc);
            data_nxt  = in_tdata;
            state_nxt = rc4_pkg::ST_RDJ;
          end
        end
      end
      rc4_pkg::ST_RDJ: begin
        si_nxt    = si;
        j_nxt     = j_r + si;
        rd_addr   = j_r + si;
        state_nxt = rc4_pkg::ST_SWP;
      end
      rc4_pkg::ST_SWP: begin
        mem_we    = 1'b1;
        mem_waddr = i_r;
        mem_wdata = sj;
        sj_nxt    = sj;
        rd_addr   = t_addr;
        kfi_nxt   = (t_addr == i_r);
        kfj_nxt   = (t_addr == j_r);
        pend_nxt  = 1'b1;
        pj_nxt    = j_r;
        pdata_nxt = si_r;
        ksv_nxt   = 1'b1;
        state_nxt = rc4_pkg::ST_IDLE;
      end
      rc4_pkg::ST_FILL: begin
        mem_we    = 1'b1;
        mem_waddr = n_r;
        mem_wdata = n_r;
        n_nxt     = n_r + 8'd1;
        if (n_r == 8'hFF) begin
          acc_nxt   = 8'd0;
          state_nxt = rc4_pkg::ST_KRN;
        end
      end
      rc4_pkg::ST_KRN: begin
        rd_addr   = n_r;
        state_nxt = rc4_pkg::ST_KRA;
      end
      rc4_pkg::ST_KRA: begin
        sn_nxt    = rd_data_r;
        acc_nxt   = acc_sum;
        rd_addr   = acc_sum;
        state_nxt = rc4_pkg::ST_KWN;
      end
      rc4_pkg::ST_KWN: begin
        mem_we    = 1'b1;
        mem_waddr = n_r;
        mem_wdata = rd_data_r;
        state_nxt = rc4_pkg::ST_KWA;
      end
      rc4_pkg::ST_KWA: begin
        mem_we    = 1'b1;
        mem_waddr = acc_r;
        mem_wdata = sn_r;
        n_nxt     = n_r + 8'd1;
        if (n_r == 8'hFF) begin
          i_nxt     = 8'd0;
          j_nxt     = 8'd0;
          state_nxt = rc4_pkg::ST_IDLE;
        end else begin
          state_nxt = rc4_pkg::ST_KRN;
        end
      end
      default: begin
        state_nxt = rc4_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= rc4_pkg::ST_IDLE;
      key_r       <= '0;
      i_r         <= '0;
      j_r         <= '0;
      pend_r      <= 1'b0;
      ksv_r       <= 1'b0;
      out_valid_r <= 1'b0;
      hold_v_r    <= 1'b0;
      fwd_r       <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      key_r       <= key_nxt;
      i_r         <= i_nxt;
      j_r         <= j_nxt;
      pend_r      <= pend_nxt;
      ksv_r       <= ksv_nxt;
      out_valid_r <= out_valid_nxt;
      hold_v_r    <= hold_v_nxt;
      fwd_r       <= fwd_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pj_r        <= pj_nxt;
    pdata_r     <= pdata_nxt;
    si_r        <= si_nxt;
    sj_r        <= sj_nxt;
    kfi_r       <= kfi_nxt;
    kfj_r       <= kfj_nxt;
    data_r      <= data_nxt;
    out_data_r  <= out_data_nxt;
    hold_data_r <= hold_data_nxt;
    n_r         <= n_nxt;
    acc_r       <= acc_nxt;
    sn_r        <= sn_nxt;
  end

`ifndef SYNTHESIS
  // a keystream byte never arrives while the hold slot is occupied
  a_no_hold_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    !(hold_v_r && ksv_r))
    else $error("keystream byte arrived with hold slot full");

  // swap cycle leaves a pending write and a keystream byte for the next cycle
  a_swap_follow: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == rc4_pkg::ST_SWP) |=> (pend_r && ksv_r && state_r == rc4_pkg::ST_IDLE))
    else $error("swap cycle not followed by pending write and keystream");

  // deferred table write is only ever held in idle
  a_pend_idle: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r |-> (state_r == rc4_pkg::ST_IDLE))
    else $error("pending table write outside idle");

  // key schedule ends with both indices cleared
  a_rekey_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == rc4_pkg::ST_KWA && n_r == 8'hFF) |=> (i_r == 8'd0 && j_r == 8'd0))
    else $error("indices not cleared after key schedule");
`endif

endmodule

/* tb/tb_rc4_stream_cipher.sv */
// Self-checking testbench for the RC4 stream cipher: key schedule, keystream and rekey handling.
module tb_rc4_stream_cipher;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned ByteW = rc4_pkg::ByteW;
  localparam int unsigned KeyW  = rc4_pkg::KeyW;

  localparam int unsigned RekeyDrain = 1400;
  localparam int unsigned TailCycles = 1400;

  logic            clk        = 1'b0;
  logic            rst_n      = 1'b0;
  logic            in_tvalid  = 1'b0;
  logic            in_tready;
  logic [7:0]      in_tdata   = '0;   // [7:0] data_byte
  logic [0:0]      in_tuser   = '0;   // [0] command
  logic            out_tvalid;
  logic            out_tready = 1'b0;
  logic [7:0]      out_tdata;         // [7:0] result_byte
  logic            cfg_valid  = 1'b0;
  logic            cfg_ready;
  logic [KeyW-1:0] cfg_data   = '0;

  logic [ByteW-1:0] perm_state [256];
  logic [ByteW-1:0] idx_i;
  logic [ByteW-1:0] idx_j;
  logic [KeyW-1:0]  key_shadow;
  logic [ByteW-1:0] expected_bytes [$];

  int error_count = 0;
  int crypt_count = 0;
  int rekey_count = 0;
  int key_count   = 0;
  int stall_left  = 0;
  bit no_gaps     = 1'b0;

  rc4_stream_cipher i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  initial begin
    #10ms;
    $display("[FAIL] regression broken");
    $finish;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_gaps || r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // key schedule over the shadow key; clears both indices
  function void run_schedule();
    logic [ByteW-1:0] acc;
    logic [ByteW-1:0] tmp;
    logic [ByteW-1:0] kb;
    for (int n = 0; n < 256; n++) perm_state[n] = n[ByteW-1:0];
    acc = '0;
    for (int n = 0; n < 256; n++) begin
      kb  = key_shadow[(n % 8) * 8 +: 8];
      acc = acc + perm_state[n] + kb;
      tmp = perm_state[n];
      perm_state[n]   = perm_state[acc];
      perm_state[acc] = tmp;
    end
    idx_i = '0;
    idx_j = '0;
  endfunction

  // one keystream step applied to a data byte
  function logic [ByteW-1:0] next_cipher_byte(input logic [ByteW-1:0] data);
    logic [ByteW-1:0] tmp;
    logic [ByteW-1:0] sel;
    idx_i = idx_i + 8'd1;
    idx_j = idx_j + perm_state[idx_i];
    tmp = perm_state[idx_i];
    perm_state[idx_i] = perm_state[idx_j];
    perm_state[idx_j] = tmp;
    sel = perm_state[idx_i] + perm_state[idx_j];
    return perm_state[sel] ^ data;
  endfunction

  task automatic report_mismatch(input string msg);
    error_count++;
    $display("%0t ns mismatch: %s", $time, msg);
  endtask

  task automatic send_item(input logic cmd, input logic [ByteW-1:0] data);
    int gap;
    logic [ByteW-1:0] want;
    gap = pick_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= data;
    in_tuser  <= cmd;
    do @(posedge clk); while (!in_tready);
    if (cmd == rc4_pkg::CMD_REKEY) begin
      run_schedule();
      rekey_count++;
    end else begin
      want = next_cipher_byte(data);
      expected_bytes = {expected_bytes, want};
      crypt_count++;
    end
  endtask

  // block idle: all results back and any rekey finished
  task automatic settle();
    in_tvalid <= 1'b0;
    while (expected_bytes.size() != 0) @(posedge clk);
    repeat (RekeyDrain) @(posedge clk);
  endtask

  task automatic write_key(input logic [KeyW-1:0] k);
    settle();
    cfg_valid <= 1'b1;
    cfg_data  <= k;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    key_shadow = k;
    key_count++;
  endtask

  // result side: scoreboard plus random backpressure
  initial begin
    logic [ByteW-1:0] want;
    forever begin
      @(posedge clk);
      if (rst_n && out_tvalid && out_tready) begin
        if (expected_bytes.size() == 0) begin
          report_mismatch($sformatf("unexpected result 0x%02h", out_tdata));
        end else begin
          want = expected_bytes.pop_front();
          if (out_tdata !== want)
            report_mismatch($sformatf("result_byte 0x%02h, want 0x%02h", out_tdata, want));
        end
      end
      if (stall_left > 0) begin
        out_tready <= 1'b0;
        stall_left--;
      end else begin
        out_tready <= 1'b1;
        if (!no_gaps && $urandom_range(0, 3) == 0) stall_left = pick_gap();
      end
    end
  end

  task automatic test_reset_key();
    send_item(rc4_pkg::CMD_REKEY, 8'h00);
    send_item(rc4_pkg::CMD_CRYPT, 8'h00);
    send_item(rc4_pkg::CMD_CRYPT, 8'hFF);
    send_item(rc4_pkg::CMD_CRYPT, 8'h00);
    send_item(rc4_pkg::CMD_CRYPT, 8'hFF);
  endtask

  task automatic test_all_ones_key();
    write_key('1);
    send_item(rc4_pkg::CMD_REKEY, 8'hFF);
    send_item(rc4_pkg::CMD_CRYPT, 8'h00);
    send_item(rc4_pkg::CMD_CRYPT, 8'hFF);
    send_item(rc4_pkg::CMD_CRYPT, 8'h80);
    send_item(rc4_pkg::CMD_CRYPT, 8'h01);
  endtask

  // new key must not disturb the running keystream until the next rekey
  task automatic test_key_write_mid_stream();
    write_key(64'h0123_4567_89AB_CDEF);
    send_item(rc4_pkg::CMD_CRYPT, 8'h55);
    send_item(rc4_pkg::CMD_CRYPT, 8'hAA);
    send_item(rc4_pkg::CMD_REKEY, 8'h5A);
    send_item(rc4_pkg::CMD_CRYPT, 8'h3C);
    send_item(rc4_pkg::CMD_CRYPT, 8'hC3);
  endtask

  task automatic test_rekey_back_to_back();
    no_gaps = 1'b1;
    send_item(rc4_pkg::CMD_CRYPT, 8'($urandom));
    send_item(rc4_pkg::CMD_REKEY, 8'($urandom));
    send_item(rc4_pkg::CMD_REKEY, 8'($urandom));
    send_item(rc4_pkg::CMD_CRYPT, 8'($urandom));
    send_item(rc4_pkg::CMD_CRYPT, 8'($urandom));
    no_gaps = 1'b0;
  endtask

  task automatic test_random_traffic();
    logic [KeyW-1:0] keys [6];
    int lens [6]      = '{60, 60, 280, 50, 50, 50};
    int rekey_pct [6] = '{5, 5, 1, 8, 5, 5};
    keys[0] = '0;
    keys[1] = 64'h5555_5555_5555_5555;
    keys[2] = {$urandom, $urandom};
    keys[3] = 64'hAAAA_AAAA_AAAA_AAAA;
    keys[4] = {$urandom, $urandom};
    keys[5] = {$urandom, $urandom};
    for (int p = 0; p < 6; p++) begin
      write_key(keys[p]);
      no_gaps = ($urandom_range(0, 3) == 0);
      send_item(rc4_pkg::CMD_REKEY, 8'($urandom));
      for (int k = 0; k < lens[p]; k++) begin
        if ($urandom_range(0, 99) < rekey_pct[p])
          send_item(rc4_pkg::CMD_REKEY, 8'($urandom));
        else
          send_item(rc4_pkg::CMD_CRYPT, 8'($urandom));
        if ($urandom_range(0, 39) == 0) no_gaps = !no_gaps;
      end
    end
    no_gaps = 1'b0;
  endtask

  initial begin
    key_shadow = '0;
    idx_i      = '0;
    idx_j      = '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_key();
    test_all_ones_key();
    test_key_write_mid_stream();
    test_rekey_back_to_back();
    test_random_traffic();

    in_tvalid <= 1'b0;
    while (expected_bytes.size() != 0) @(posedge clk);
    repeat (TailCycles) @(posedge clk);

    $display("covered %0d crypt bytes and %0d rekeys across %0d key writes",
             crypt_count, rekey_count, key_count);
    $display("random stalls on both channels, %0d mismatches", error_count);
    if (error_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
